// File: rtl/phc_pkg.sv
`timescale 1ns / 1ps
package phc_pkg;

	localparam int POS_W       = 8;
	localparam int MAP_AW      = 2 * POS_W;
	localparam int TIME_W      = 48;
	localparam int CHARGE_IN_W = 14;
	localparam int SIZE_W      = 7;
	localparam int QSUM_OUT_W  = 20;
	localparam int CENT_W      = 16;
	localparam int FRAC_W      = 8;
	localparam int QUO_W       = 16;
	localparam int STEP_W      = $clog2(QUO_W);
	localparam int CFG_W       = 9;
	localparam int CFG_IDX_W   = 1;

	// Sensor size caps applied to the row and column registers.
	localparam int MAX_ROWS = 256;
	localparam int MAX_COLS = 256;

	localparam int MAX_HITS_DEF    = 64;
	localparam int CHARGE_BITS_DEF = 14;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;
	localparam logic [CFG_W-1:0]     SENSOR_RESET     = 9'd256;

	typedef struct packed {
		logic [POS_W-1:0]       hit_row;
		logic [POS_W-1:0]       hit_column;
		logic [CHARGE_IN_W-1:0] hit_charge;
		logic [TIME_W-1:0]      hit_time;
		logic                   last_hit;
	} hit_t;

	typedef struct packed {
		logic [SIZE_W-1:0]     cluster_size;
		logic [QSUM_OUT_W-1:0] charge_sum;
		logic [CENT_W-1:0]     centroid_row;
		logic [CENT_W-1:0]     centroid_column;
		logic [TIME_W-1:0]     seed_time;
		logic                  zero_charge;
		logic                  hits_dropped;
		logic                  last_cluster;
	} cluster_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SEED,
		ST_PROBE,
		ST_CHECK,
		ST_NB_ACC,
		ST_POP,
		ST_POP_RD,
		ST_CENTER,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT,
		ST_FINISH,
		ST_FL_RD,
		ST_FL_WR
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic store;
		logic scan_skip;
		logic seed_rd;
		logic seed_acc;
		logic probe_next;
		logic take;
		logic nb_acc;
		logic pop;
		logic pop_rd;
		logic center;
		logic div_go;
		logic emit;
		logic fin;
		logic fl_wr;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic hit_last;
		logic scan_end;
		logic seed_used;
		logic probe_ok;
		logic probe_last;
		logic take_ok;
		logic stack_empty;
		logic sum_zero;
		logic div_busy;
		logic out_free;
		logic pend;
		logic fl_last;
	} sts_t;

endpackage

// File: rtl/phc_ram.sv
`timescale 1ns / 1ps
module phc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/phc_div.sv
`timescale 1ns / 1ps
module phc_div
	import phc_pkg::*;
#(
	parameter int DEN_W = 20,
	parameter int NUM_W = 28
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num_a,
	input  logic [NUM_W-1:0] num_b,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [QUO_W-1:0] quo_a,
	output logic [QUO_W-1:0] quo_b
);

	localparam int RW = NUM_W + FRAC_W;

	logic [RW-1:0]     rem_a_q, rem_b_q, den_sh_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [QUO_W-1:0]  quo_a_q, quo_b_q;
	logic              ge_a, ge_b;

	// Quotient is known to fit in QUO_W bits, so one restoring step per quotient bit.
	assign ge_a = rem_a_q >= den_sh_q;
	assign ge_b = rem_b_q >= den_sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (&step_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_a_q  <= {num_a, {FRAC_W{1'b0}}};
			rem_b_q  <= {num_b, {FRAC_W{1'b0}}};
			den_sh_q <= RW'(den) << (QUO_W - 1);
			quo_a_q  <= '0;
			quo_b_q  <= '0;
		end else if (busy_q) begin
			if (ge_a) begin
				rem_a_q <= rem_a_q - den_sh_q;
			end
			if (ge_b) begin
				rem_b_q <= rem_b_q - den_sh_q;
			end
			quo_a_q  <= {quo_a_q[QUO_W-2:0], ge_a};
			quo_b_q  <= {quo_b_q[QUO_W-2:0], ge_b};
			den_sh_q <= den_sh_q >> 1;
		end
	end

	assign busy  = busy_q;
	assign quo_a = quo_a_q;
	assign quo_b = quo_b_q;

endmodule

// File: rtl/phc_ctrl.sv
`timescale 1ns / 1ps
module phc_ctrl
	import phc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic hit_valid,
	output logic hit_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (hit_valid && sts.hit_last) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_end) state_d = ST_FINISH;
				else if (!sts.seed_used) state_d = ST_SEED;
			end
			ST_SEED: state_d = ST_PROBE;
			ST_PROBE: begin
				if (sts.probe_ok) state_d = ST_CHECK;
				else if (sts.probe_last) state_d = ST_POP;
			end
			ST_CHECK: begin
				if (sts.take_ok) state_d = ST_NB_ACC;
				else if (sts.probe_last) state_d = ST_POP;
				else state_d = ST_PROBE;
			end
			ST_NB_ACC: state_d = sts.probe_last ? ST_POP : ST_PROBE;
			ST_POP: state_d = sts.stack_empty ? ST_DIV_GO : ST_POP_RD;
			ST_POP_RD: state_d = ST_CENTER;
			ST_CENTER: state_d = ST_PROBE;
			ST_DIV_GO: state_d = sts.sum_zero ? ST_EMIT : ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (!sts.div_busy) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.pend || sts.out_free) state_d = ST_SCAN;
			end
			ST_FINISH: begin
				if (!sts.pend || sts.out_free) state_d = ST_FL_RD;
			end
			ST_FL_RD: state_d = ST_FL_WR;
			ST_FL_WR: begin
				if (sts.fl_last) state_d = ST_IDLE;
				else state_d = ST_FL_RD;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		hit_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				hit_ready = 1'b1;
				cmd.store = hit_valid;
			end
			ST_SCAN: begin
				if (!sts.scan_end) begin
					cmd.scan_skip = sts.seed_used;
					cmd.seed_rd   = !sts.seed_used;
				end
			end
			ST_SEED: cmd.seed_acc = 1'b1;
			ST_PROBE: cmd.probe_next = !sts.probe_ok;
			ST_CHECK: begin
				cmd.take       = sts.take_ok;
				cmd.probe_next = !sts.take_ok;
			end
			ST_NB_ACC: begin
				cmd.nb_acc     = 1'b1;
				cmd.probe_next = 1'b1;
			end
			ST_POP: cmd.pop = !sts.stack_empty;
			ST_POP_RD: cmd.pop_rd = 1'b1;
			ST_CENTER: cmd.center = 1'b1;
			ST_DIV_GO: cmd.div_go = !sts.sum_zero;
			ST_EMIT: cmd.emit = !sts.pend || sts.out_free;
			ST_FINISH: cmd.fin = !sts.pend || sts.out_free;
			ST_FL_WR: cmd.fl_wr = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

// File: rtl/phc_dp.sv
`timescale 1ns / 1ps
module phc_dp
	import phc_pkg::*;
#(
	parameter int MAX_HITS    = MAX_HITS_DEF,
	parameter int CHARGE_BITS = CHARGE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  hit_t                 hit,
	output logic                 cluster_valid,
	input  logic                 cluster_ready,
	output cluster_t             cluster,
	input  cmd_t                 cmd,
	output sts_t                 sts
);

	localparam int QW     = (CHARGE_BITS < CHARGE_IN_W) ? CHARGE_BITS : CHARGE_IN_W;
	localparam int IDX_W  = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
	localparam int CNT_W  = $clog2(MAX_HITS + 1);
	localparam int QSUM_W = QW + IDX_W;
	localparam int PSUM_W = QSUM_W + POS_W;
	localparam int PROD_W = POS_W + QW;

	logic [CFG_W-1:0] row_count_q, column_count_q;

	logic [MAP_AW-1:0] clr_q;
	logic [CNT_W-1:0]  cnt_q, scan_q, depth_q, members_q;
	logic              overflow_q;
	logic [MAX_HITS-1:0] used_q;
	logic [1:0]        kr_q, kc_q;
	logic [POS_W-1:0]  crow_q, ccol_q;
	logic [TIME_W-1:0] seed_time_q;
	logic [QSUM_W-1:0] qsum_q;
	logic [PSUM_W-1:0] rsum_q, csum_q;

	cluster_t res_q, out_q, res_new, res_fwd;
	logic     pend_q, out_valid_q;

	logic              room;
	logic [MAP_AW-1:0] hit_pos;
	logic              map_we;
	logic [MAP_AW-1:0] map_waddr, map_raddr;
	logic [CNT_W-1:0]  map_wdata, map_rdata;
	logic [IDX_W-1:0]  hit_waddr, hit_raddr, scan_idx, take_idx;
	logic [MAP_AW-1:0] pos_rdata;
	logic [QW-1:0]     chg_rdata;
	logic [TIME_W-1:0] time_rdata;
	logic [IDX_W-1:0]  stk_rdata, stk_raddr;
	logic [8:0]        rp, cp;
	logic              map_ok;
	logic [PROD_W-1:0] prod_r, prod_c;
	logic              div_busy, sum_zero, out_free;
	logic [QUO_W-1:0]  quo_r, quo_c;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= SENSOR_RESET;
			column_count_q <= SENSOR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_COUNT:    row_count_q    <= cfg_data;
				REG_COLUMN_COUNT: column_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign room      = cnt_q < CNT_W'(MAX_HITS);
	assign hit_pos   = {hit.hit_row, hit.hit_column};
	assign hit_waddr = cnt_q[IDX_W-1:0];
	assign scan_idx  = scan_q[IDX_W-1:0];
	assign take_idx  = IDX_W'(map_rdata - 1'b1);
	assign stk_raddr = IDX_W'(depth_q - 1'b1);

	always_comb begin
		if (cmd.take) hit_raddr = take_idx;
		else if (cmd.pop_rd) hit_raddr = stk_rdata;
		else hit_raddr = scan_idx;
	end

	// Probe offsets run from -1 to +1; rp and cp hold the probed row and column plus one.
	assign rp = {1'b0, crow_q} + 9'(kr_q);
	assign cp = {1'b0, ccol_q} + 9'(kc_q);
	assign map_raddr = {POS_W'(rp - 1'b1), POS_W'(cp - 1'b1)};

	always_comb begin
		map_we    = cmd.clr_step || (cmd.store && room) || cmd.fl_wr;
		map_waddr = pos_rdata;
		map_wdata = '0;
		if (cmd.clr_step) begin
			map_waddr = clr_q;
		end else if (cmd.store) begin
			map_waddr = hit_pos;
			map_wdata = cnt_q + 1'b1;
		end
	end

	phc_ram #(.WIDTH(CNT_W), .DEPTH(1 << MAP_AW)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(map_raddr), .rdata(map_rdata)
	);

	phc_ram #(.WIDTH(MAP_AW), .DEPTH(MAX_HITS)) u_pos (
		.clk(clk), .we(cmd.store && room), .waddr(hit_waddr), .wdata(hit_pos),
		.raddr(hit_raddr), .rdata(pos_rdata)
	);

	phc_ram #(.WIDTH(QW), .DEPTH(MAX_HITS)) u_chg (
		.clk(clk), .we(cmd.store && room), .waddr(hit_waddr),
		.wdata(hit.hit_charge[QW-1:0]), .raddr(hit_raddr), .rdata(chg_rdata)
	);

	phc_ram #(.WIDTH(TIME_W), .DEPTH(MAX_HITS)) u_time (
		.clk(clk), .we(cmd.store && room), .waddr(hit_waddr), .wdata(hit.hit_time),
		.raddr(hit_raddr), .rdata(time_rdata)
	);

	phc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_HITS)) u_stack (
		.clk(clk), .we(cmd.take), .waddr(depth_q[IDX_W-1:0]), .wdata(take_idx),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	assign prod_r = pos_rdata[MAP_AW-1:POS_W] * chg_rdata;
	assign prod_c = pos_rdata[POS_W-1:0] * chg_rdata;

	assign map_ok = (map_rdata != '0) && (map_rdata <= CNT_W'(MAX_HITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			cnt_q      <= '0;
			scan_q     <= '0;
			depth_q    <= '0;
			overflow_q <= 1'b0;
			used_q     <= '0;
			kr_q       <= '0;
			kc_q       <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.store) begin
				if (room) cnt_q <= cnt_q + 1'b1;
				else overflow_q <= 1'b1;
			end
			if (cmd.fin || (cmd.fl_wr && sts.fl_last)) begin
				scan_q <= '0;
			end else if (cmd.scan_skip || cmd.emit || cmd.fl_wr) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.seed_rd) used_q[scan_idx] <= 1'b1;
			if (cmd.take) begin
				used_q[take_idx] <= 1'b1;
				depth_q          <= depth_q + 1'b1;
			end
			if (cmd.pop) depth_q <= depth_q - 1'b1;
			if (cmd.seed_acc || cmd.center) begin
				kr_q <= '0;
				kc_q <= '0;
			end else if (cmd.probe_next) begin
				if (kc_q == 2'd2) begin
					kc_q <= '0;
					kr_q <= kr_q + 1'b1;
				end else begin
					kc_q <= kc_q + 1'b1;
				end
			end
			if (cmd.fl_wr && sts.fl_last) begin
				cnt_q      <= '0;
				overflow_q <= 1'b0;
				used_q     <= '0;
			end
		end
	end

	// Cluster accumulators and probe center.
	always_ff @(posedge clk) begin
		if (cmd.seed_acc) begin
			members_q   <= CNT_W'(1);
			qsum_q      <= QSUM_W'(chg_rdata);
			rsum_q      <= PSUM_W'(prod_r);
			csum_q      <= PSUM_W'(prod_c);
			seed_time_q <= time_rdata;
		end else if (cmd.nb_acc) begin
			members_q <= members_q + 1'b1;
			qsum_q    <= qsum_q + QSUM_W'(chg_rdata);
			rsum_q    <= rsum_q + PSUM_W'(prod_r);
			csum_q    <= csum_q + PSUM_W'(prod_c);
		end
		if (cmd.seed_acc || cmd.center) begin
			crow_q <= pos_rdata[MAP_AW-1:POS_W];
			ccol_q <= pos_rdata[POS_W-1:0];
		end
	end

	phc_div #(.DEN_W(QSUM_W), .NUM_W(PSUM_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_go),
		.num_a(rsum_q), .num_b(csum_q), .den(qsum_q),
		.busy(div_busy), .quo_a(quo_r), .quo_b(quo_c)
	);

	assign sum_zero = qsum_q == '0;
	assign out_free = !out_valid_q || cluster_ready;

	always_comb begin
		res_new                 = '0;
		res_new.cluster_size    = SIZE_W'(members_q);
		res_new.charge_sum      = QSUM_OUT_W'(qsum_q);
		res_new.centroid_row    = sum_zero ? '0 : quo_r;
		res_new.centroid_column = sum_zero ? '0 : quo_c;
		res_new.seed_time       = seed_time_q;
		res_new.zero_charge     = sum_zero;
		res_new.hits_dropped    = overflow_q;
		res_new.last_cluster    = 1'b0;
	end

	always_comb begin
		res_fwd              = res_q;
		res_fwd.last_cluster = cmd.fin;
	end

	// One cluster is held back until the next one or the end of the scan shows
	// whether it is the final cluster of the event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) pend_q <= 1'b1;
			else if (cmd.fin) pend_q <= 1'b0;
			if ((cmd.emit || cmd.fin) && pend_q) out_valid_q <= 1'b1;
			else if (cluster_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) res_q <= res_new;
		if ((cmd.emit || cmd.fin) && pend_q) out_q <= res_fwd;
	end

	assign cluster_valid = out_valid_q;
	assign cluster       = out_q;

	always_comb begin
		sts             = '0;
		sts.clr_done    = &clr_q;
		sts.hit_last    = hit.last_hit;
		sts.scan_end    = scan_q == cnt_q;
		sts.seed_used   = used_q[scan_idx];
		sts.probe_ok    = (rp != '0) && (rp <= row_count_q) && (int'(rp) <= MAX_ROWS)
			&& (cp != '0) && (cp <= column_count_q) && (int'(cp) <= MAX_COLS);
		sts.probe_last  = (kr_q == 2'd2) && (kc_q == 2'd2);
		sts.take_ok     = map_ok && !used_q[take_idx];
		sts.stack_empty = depth_q == '0;
		sts.sum_zero    = sum_zero;
		sts.div_busy    = div_busy;
		sts.out_free    = out_free;
		sts.pend        = pend_q;
		sts.fl_last     = (scan_q + 1'b1) == cnt_q;
	end

endmodule

// File: rtl/pixel_hit_clustering_top.sv
`timescale 1ns / 1ps
// Pixel hit clusterer. Hits of one event are taken one per cycle and stored; the
// hit marked last closes the event, and the block then groups the stored hits into
// 8-connected clusters, seeded in input order, and sends one item per cluster with
// size, charge sum, Q8.8 charge-weighted centroids and seed time. While an event is
// being clustered no hit is accepted. Clustering is a serial walk driven by the
// position map memory: hits already in a cluster are skipped, any other hit starts
// a seed, each member gets a 3x3 probe (positions outside the sensor are skipped,
// the others are looked up and free neighbors are taken onto the stack), the stack
// is popped until empty, the centroid division runs for each cluster with nonzero
// charge, each cluster is emitted, the scan is closed and the map entries of the
// stored hits are then cleared. After reset the block clears all 65536 entries of
// the position map before it accepts the first hit; configuration writes are taken
// at any time.
module pixel_hit_clustering_top
	import phc_pkg::*;
#(
	parameter int MAX_HITS    = MAX_HITS_DEF,
	parameter int CHARGE_BITS = CHARGE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 hit_valid,
	output logic                 hit_ready,
	input  hit_t                 hit,
	output logic                 cluster_valid,
	input  logic                 cluster_ready,
	output cluster_t             cluster
);

	cmd_t cmd;
	sts_t sts;

	phc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .hit_valid(hit_valid), .hit_ready(hit_ready),
		.sts(sts), .cmd(cmd)
	);

	phc_dp #(.MAX_HITS(MAX_HITS), .CHARGE_BITS(CHARGE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.hit(hit), .cluster_valid(cluster_valid), .cluster_ready(cluster_ready),
		.cluster(cluster), .cmd(cmd), .sts(sts)
	);

endmodule

// File: test/pixel_hit_clustering_top_tb.sv
`timescale 1ns / 1ps
module pixel_hit_clustering_top_tb;
	import phc_pkg::*;

	localparam int WATCHDOG_LIMIT = 300000;
	localparam int DRAIN_CYCLES   = 400;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// Holds the clustering state of the current event and the clusters still owed.
	class cluster_scoreboard;
		bit [CFG_W-1:0] row_count = SENSOR_RESET;
		bit [CFG_W-1:0] column_count = SENSOR_RESET;
		int pos_map[int];
		bit [15:0] positions[64];
		bit [13:0] charges[64];
		bit [47:0] times[64];
		bit used[64];
		int n_hits;
		bit overflow;
		cluster_t owed_q[$];
		int errors;
		int members;
		int stack[64];
		int depth;
		longint unsigned qsum, rsum, csum;

		function void take(int j);
			used[j] = 1;
			members++;
			qsum += charges[j];
			rsum += longint'(positions[j][15:8]) * charges[j];
			csum += longint'(positions[j][7:0]) * charges[j];
			if (depth < 64) begin
				stack[depth] = j;
				depth++;
			end
		endfunction

		function void probe(int idx, int rows, int cols);
			int r0, c0, key;
			r0 = int'(positions[idx][15:8]);
			c0 = int'(positions[idx][7:0]);
			for (int r = r0 - 1; r <= r0 + 1; r++) begin
				if (r < 0 || r >= rows || r > 255) continue;
				for (int c = c0 - 1; c <= c0 + 1; c++) begin
					if (c < 0 || c >= cols || c > 255) continue;
					key = (r << 8) | c;
					if (!pos_map.exists(key)) continue;
					if (used[pos_map[key]]) continue;
					take(pos_map[key]);
				end
			end
		endfunction

		function void note_hit(hit_t h);
			int rows, cols;
			cluster_t cl;
			if (n_hits < 64) begin
				positions[n_hits] = {h.hit_row, h.hit_column};
				charges[n_hits] = h.hit_charge;
				times[n_hits] = h.hit_time;
				pos_map[int'({h.hit_row, h.hit_column})] = n_hits;
				n_hits++;
			end else
				overflow = 1;
			if (!h.last_hit) return;
			rows = row_count < MAX_ROWS ? int'(row_count) : MAX_ROWS;
			cols = column_count < MAX_COLS ? int'(column_count) : MAX_COLS;
			for (int i = 0; i < n_hits; i++) begin
				if (used[i]) continue;
				members = 0;
				qsum = 0;
				rsum = 0;
				csum = 0;
				depth = 0;
				take(i);
				// The seed is probed directly and never sits on the stack.
				depth = 0;
				probe(i, rows, cols);
				while (depth > 0) begin
					depth--;
					probe(stack[depth], rows, cols);
				end
				cl = '0;
				cl.cluster_size = SIZE_W'(members);
				cl.charge_sum = QSUM_OUT_W'(qsum);
				if (qsum != 0) begin
					cl.centroid_row = CENT_W'((rsum << 8) / qsum);
					cl.centroid_column = CENT_W'((csum << 8) / qsum);
				end
				cl.seed_time = times[i];
				cl.zero_charge = (qsum == 0);
				cl.hits_dropped = overflow;
				owed_q.push_back(cl);
			end
			owed_q[owed_q.size() - 1].last_cluster = 1;
			pos_map.delete();
			used = '{default: 0};
			n_hits = 0;
			overflow = 0;
		endfunction

		function void check_cluster(cluster_t got);
			cluster_t exp;
			bit bad;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected cluster %p", got);
				return;
			end
			exp = owed_q.pop_front();
			bad = got.cluster_size != exp.cluster_size ||
				got.charge_sum != exp.charge_sum ||
				got.centroid_row != exp.centroid_row ||
				got.centroid_column != exp.centroid_column ||
				got.seed_time != exp.seed_time ||
				got.zero_charge != exp.zero_charge ||
				got.hits_dropped != exp.hits_dropped ||
				got.last_cluster != exp.last_cluster;
			if (bad) begin
				errors++;
				if (errors <= 10) $display("cluster mismatch: expected %p, got %p", exp, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic hit_valid = 0;
	logic hit_ready;
	hit_t hit = '0;
	logic cluster_valid;
	logic cluster_ready = 0;
	cluster_t cluster;

	cluster_scoreboard sb = new();
	idle_mode_t idle_mode = IDLE_NONE;
	int quiet_cycles = 0;
	int hits_sent = 0;

	pixel_hit_clustering_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.hit_valid(hit_valid), .hit_ready(hit_ready), .hit(hit),
		.cluster_valid(cluster_valid), .cluster_ready(cluster_ready), .cluster(cluster)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && ((hit_valid && hit_ready) || (cluster_valid && cluster_ready)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n) begin
			if (hit_valid && hit_ready) sb.note_hit(hit);
			if (cluster_valid && cluster_ready) sb.check_cluster(cluster);
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH)
			cluster_ready = $urandom_range(99) >= (idle_mode == IDLE_BOTH ? 7 : 73);
		else
			cluster_ready = 1;
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = value;
		if (idx == REG_ROW_COUNT) sb.row_count = value;
		else sb.column_count = value;
		@(negedge clk);
		cfg_we = 0;
	endtask

	// Entered and left at a falling edge; valid stays high between back-to-back items.
	task automatic send_hit(bit [7:0] row, bit [7:0] col, bit [13:0] charge,
			bit [47:0] stamp, bit last);
		int gap_pct;
		gap_pct = idle_mode == IDLE_SENDER ? 73 : idle_mode == IDLE_BOTH ? 7 : 0;
		while ($urandom_range(99) < gap_pct) begin
			hit_valid = 0;
			@(negedge clk);
		end
		hit = '{hit_row: row, hit_column: col, hit_charge: charge, hit_time: stamp,
			last_hit: last};
		hit_valid = 1;
		do @(posedge clk); while (!hit_ready);
		@(negedge clk);
		hits_sent++;
	endtask

	task automatic drain();
		hit_valid = 0;
		while (sb.owed_q.size() > 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic bit [13:0] pick_charge();
		case ($urandom_range(9))
			0: return 14'd0;
			1: return 14'h3fff;
			2, 3: return 14'($urandom_range(15));
			default: return 14'($urandom);
		endcase
	endfunction

	task automatic random_event();
		int n, base_r, base_c, spread;
		bit [47:0] stamp;
		n = $urandom_range(99) < 8 ? $urandom_range(40, 70) : $urandom_range(1, 12);
		base_r = $urandom_range(255);
		base_c = $urandom_range(255);
		spread = $urandom_range(1, 3);
		for (int k = 0; k < n; k++) begin
			stamp = 48'({$urandom, $urandom});
			send_hit(8'(base_r + int'($urandom_range(2 * spread)) - spread),
				8'(base_c + int'($urandom_range(2 * spread)) - spread),
				pick_charge(), stamp, k == n - 1);
		end
	endtask

	int row_settings[6] = '{256, 1, 0, 511, 20, 3};
	int col_settings[6] = '{256, 1, 5, 16, 300, 255};

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1;

		// Corners, duplicate positions and a lone zero-charge hit.
		send_hit(0, 0, 0, 48'h0, 0);
		send_hit(0, 1, 14'h3fff, 48'hffff_ffff_ffff, 0);
		send_hit(1, 1, 100, 48'h1234, 0);
		send_hit(0, 0, 7, 48'h5555_5555_5555, 0);
		send_hit(255, 255, 14'h3fff, 48'haaaa_aaaa_aaaa, 0);
		send_hit(255, 254, 1, 48'h1, 0);
		send_hit(1, 1, 50, 48'h2, 1);
		send_hit(77, 33, 0, 48'h3, 1);
		send_hit(128, 128, 9, 48'h4, 0);
		send_hit(130, 130, 9, 48'h5, 0);
		send_hit(129, 129, 0, 48'h6, 0);
		send_hit(128, 128, 0, 48'h7, 1);
		drain();

		for (int p = 0; p < 8; p++) begin
			write_reg(REG_ROW_COUNT, CFG_W'(row_settings[p % 6]));
			write_reg(REG_COLUMN_COUNT, CFG_W'(col_settings[p % 6]));
			idle_mode = idle_mode_t'(p % 4);
			while (hits_sent < 12 + (p + 1) * 53) random_event();
			drain();
			idle_mode = IDLE_NONE;
		end

		// Leftover expectations at the end count as failures.
		if (sb.errors == 0 && sb.owed_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
